@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PLS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PLS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define PLS_ASSERT(lbl, clk, rstn, prop, msg)
`define PLS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/pls_pkg.sv @@
// Types and constants for the positional list store.
// No dependencies.
`default_nettype none

package pls_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 7;
	localparam int DATA_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		CMD_GET = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_SHOW = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FAIL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_GET,
		S_SHIFT,
		S_INS_WR,
		S_SHOW,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_t command;
		pos_t position;
		logic signed [DATA_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		status_t status;
		logic signed [DATA_W-1:0] value_res;
		logic last;
	} res_item_t;

endpackage

`default_nettype wire

@@ rtl/positional_list_store.sv @@
// Positional list store: ordered list of signed words in one synchronous RAM.
// Depends on pls_pkg and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_ready  | pls_pkg::cmd_item_t
//  res     | out       | res_valid/res_ready  | pls_pkg::res_item_t
//
// Insert and delete shift the entries behind the position one at a time; insert
// then writes the new value. An output stall holds the sequencer in its state.
// The single read and single write port of the element RAM move one entry a cycle.
// Reset clears the element count, the state and the result valid; the RAM is not cleared.
// A new command is taken whenever the sequencer is idle, even while a result waits.
`default_nettype none

module positional_list_store (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire pls_pkg::cmd_item_t cmd,
	output logic res_valid,
	input wire logic res_ready,
	output pls_pkg::res_item_t res
);

`include "assert_macros.svh"

	pls_pkg::state_t state_q, state_d;
	pls_pkg::cmd_t cmd_q;
	pls_pkg::pos_t pos_q;
	logic signed [pls_pkg::DATA_W-1:0] val_q;
	pls_pkg::status_t status_q, status_d;
	pls_pkg::addr_t idx_q, idx_d;
	pls_pkg::cnt_t count_q;
	logic count_inc, count_dec;

	logic [pls_pkg::DATA_W-1:0] mem_q [pls_pkg::CAPACITY];
	logic [pls_pkg::DATA_W-1:0] rd_data_q;
	logic rd_en, wr_en;
	pls_pkg::addr_t rd_addr, wr_addr;
	logic [pls_pkg::DATA_W-1:0] wr_data;

	logic res_valid_q;
	pls_pkg::res_item_t res_q, res_d;
	logic load_res, res_free, accept;

	pls_pkg::pos_t cnt_ext;
	logic pos_zero, pos_gt_cnt, pos_is_end, pos_is_cnt, full, cnt_zero;
	logic get_fail, ins_fail, del_fail;
	logic ins_done, del_done, show_last;

	assign accept = cmd_valid && cmd_ready;
	assign res_free = !res_valid_q || res_ready;

	assign cnt_ext = pls_pkg::pos_t'(count_q);
	assign pos_zero = pos_q == '0;
	assign pos_gt_cnt = pos_q > cnt_ext;
	assign pos_is_end = pos_q == cnt_ext + pls_pkg::pos_t'(1);
	assign pos_is_cnt = pos_q == cnt_ext;
	assign full = count_q == pls_pkg::cnt_t'(pls_pkg::CAPACITY);
	assign cnt_zero = count_q == '0;
	assign get_fail = pos_zero || pos_gt_cnt;
	assign del_fail = get_fail;
	assign ins_fail = pos_zero || (pos_gt_cnt && !pos_is_end) || full;

	assign ins_done = pls_pkg::pos_t'(idx_q) == pos_q;
	assign del_done = pls_pkg::cnt_t'(idx_q) + pls_pkg::cnt_t'(2) == count_q;
	assign show_last = pls_pkg::cnt_t'(idx_q) + pls_pkg::cnt_t'(1) == count_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pls_pkg::S_IDLE: begin
				if (accept) begin
					state_d = pls_pkg::S_DECODE;
				end
			end
			pls_pkg::S_DECODE: begin
				unique case (cmd_q)
					pls_pkg::CMD_GET:
						state_d = get_fail ? pls_pkg::S_RESP : pls_pkg::S_GET;
					pls_pkg::CMD_INSERT:
						state_d = (ins_fail || pos_is_end) ? pls_pkg::S_RESP : pls_pkg::S_SHIFT;
					pls_pkg::CMD_DELETE:
						state_d = (del_fail || pos_is_cnt) ? pls_pkg::S_RESP : pls_pkg::S_SHIFT;
					pls_pkg::CMD_SHOW:
						state_d = cnt_zero ? pls_pkg::S_RESP : pls_pkg::S_SHOW;
					default: state_d = pls_pkg::S_RESP;
				endcase
			end
			pls_pkg::S_SHIFT: begin
				if (cmd_q == pls_pkg::CMD_INSERT) begin
					if (ins_done) begin
						state_d = pls_pkg::S_INS_WR;
					end
				end else if (del_done) begin
					state_d = pls_pkg::S_RESP;
				end
			end
			pls_pkg::S_INS_WR: state_d = pls_pkg::S_RESP;
			pls_pkg::S_GET, pls_pkg::S_RESP: begin
				if (res_free) begin
					state_d = pls_pkg::S_IDLE;
				end
			end
			pls_pkg::S_SHOW: begin
				if (res_free && show_last) begin
					state_d = pls_pkg::S_IDLE;
				end
			end
			default: state_d = pls_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = state_q == pls_pkg::S_IDLE;
		rd_en = 1'b0;
		rd_addr = idx_q;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		load_res = 1'b0;
		res_d = '{status: pls_pkg::ST_OK, value_res: '0, last: 1'b1};
		status_d = status_q;
		idx_d = idx_q;
		count_inc = 1'b0;
		count_dec = 1'b0;
		unique case (state_q)
			pls_pkg::S_DECODE: begin
				status_d = pls_pkg::ST_OK;
				unique case (cmd_q)
					pls_pkg::CMD_GET: begin
						if (get_fail) begin
							status_d = pls_pkg::ST_FAIL;
						end else begin
							rd_en = 1'b1;
							rd_addr = pls_pkg::addr_t'(pos_q - pls_pkg::pos_t'(1));
						end
					end
					pls_pkg::CMD_INSERT: begin
						if (ins_fail) begin
							status_d = pls_pkg::ST_FAIL;
						end else if (pos_is_end) begin
							wr_en = 1'b1;
							wr_addr = pls_pkg::addr_t'(pos_q - pls_pkg::pos_t'(1));
							wr_data = val_q;
							count_inc = 1'b1;
						end else begin
							rd_en = 1'b1;
							rd_addr = pls_pkg::addr_t'(count_q - pls_pkg::cnt_t'(1));
							idx_d = pls_pkg::addr_t'(count_q);
						end
					end
					pls_pkg::CMD_DELETE: begin
						if (del_fail) begin
							status_d = pls_pkg::ST_FAIL;
						end else if (pos_is_cnt) begin
							count_dec = 1'b1;
						end else begin
							rd_en = 1'b1;
							rd_addr = pls_pkg::addr_t'(pos_q);
							idx_d = pls_pkg::addr_t'(pos_q - pls_pkg::pos_t'(1));
						end
					end
					pls_pkg::CMD_SHOW: begin
						if (cnt_zero) begin
							status_d = pls_pkg::ST_EMPTY;
						end else begin
							rd_en = 1'b1;
							rd_addr = '0;
							idx_d = '0;
						end
					end
					default: status_d = pls_pkg::ST_FAIL;
				endcase
			end
			pls_pkg::S_SHIFT: begin
				wr_en = 1'b1;
				wr_addr = idx_q;
				if (cmd_q == pls_pkg::CMD_INSERT) begin
					if (!ins_done) begin
						rd_en = 1'b1;
						rd_addr = idx_q - pls_pkg::addr_t'(2);
						idx_d = idx_q - pls_pkg::addr_t'(1);
					end
				end else if (del_done) begin
					count_dec = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = idx_q + pls_pkg::addr_t'(2);
					idx_d = idx_q + pls_pkg::addr_t'(1);
				end
			end
			pls_pkg::S_INS_WR: begin
				wr_en = 1'b1;
				wr_addr = pls_pkg::addr_t'(pos_q - pls_pkg::pos_t'(1));
				wr_data = val_q;
				count_inc = 1'b1;
			end
			pls_pkg::S_GET: begin
				load_res = res_free;
				res_d.value_res = rd_data_q;
			end
			pls_pkg::S_RESP: begin
				load_res = res_free;
				res_d.status = status_q;
			end
			pls_pkg::S_SHOW: begin
				load_res = res_free;
				res_d.value_res = rd_data_q;
				res_d.last = show_last;
				if (res_free && !show_last) begin
					rd_en = 1'b1;
					rd_addr = idx_q + pls_pkg::addr_t'(1);
					idx_d = idx_q + pls_pkg::addr_t'(1);
				end
			end
			default: begin
				cmd_ready = state_q == pls_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::S_IDLE;
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_inc) begin
				count_q <= count_q + pls_pkg::cnt_t'(1);
			end else if (count_dec) begin
				count_q <= count_q - pls_pkg::cnt_t'(1);
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd.command;
			pos_q <= cmd.position;
			val_q <= cmd.value;
		end
		status_q <= status_d;
		idx_q <= idx_d;
		if (load_res) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`PLS_ASSERT(a_count_range, clk, arst_n, count_q <= pls_pkg::cnt_t'(pls_pkg::CAPACITY), "element count above capacity")
	`PLS_ASSERT_IMPL(a_rd_in_list, clk, arst_n, rd_en, pls_pkg::cnt_t'(rd_addr) < count_q, "read beyond list end")
	`PLS_ASSERT_IMPL(a_wr_in_list, clk, arst_n, wr_en, pls_pkg::cnt_t'(wr_addr) <= count_q, "write beyond list end")
	`PLS_ASSERT_IMPL(a_load_free, clk, arst_n, load_res, res_free, "result register overwritten while held")

endmodule

`default_nettype wire
